// ----- hdl/deq_pkg.sv -----
// Shared types and constants for the double-ended queue unit.
package deq_pkg;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_DEF = 64;

    // Input word: cmd, value; padded to whole bytes
    localparam int S_DATA_W = ((CMD_W + DATA_W + 7) / 8) * 8;
    // Result word: popped_value, found, first_value, last_value, entry_count, status
    localparam int M_FIELDS_W = 3 * DATA_W + 1 + COUNT_W + STATUS_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4
    } deq_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } deq_status_t;

    // Shift/update command broadcast to every cell; at most one bit set
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } deq_op_t;

endpackage

// ----- hdl/deq_cell.sv -----
// One storage cell of the queue chain: holds an entry and trades it with its neighbors.
module deq_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  deq_pkg::deq_op_t           op,
    input  logic [deq_pkg::DATA_W-1:0] key,
    input  logic [deq_pkg::DATA_W-1:0] left_val,
    input  logic                       left_vld,
    input  logic [deq_pkg::DATA_W-1:0] right_val,
    input  logic                       right_vld,
    output logic [deq_pkg::DATA_W-1:0] val,
    output logic                       vld,
    output logic                       is_last,
    output logic                       match
);
    import deq_pkg::*;

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic              vld_reg;
    logic              vld_next;

    assign val     = val_reg;
    assign vld     = vld_reg;
    assign is_last = vld_reg & ~right_vld;
    assign match   = vld_reg & (val_reg == key);

    always_comb begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (op.push_front) begin
            // shift toward the back, take the left neighbor's entry
            val_next = left_val;
            vld_next = left_vld;
        end else if (op.push_back) begin
            // first empty cell takes the new word
            if (!vld_reg && left_vld) begin
                val_next = key;
                vld_next = 1'b1;
            end
        end else if (op.pop_front) begin
            val_next = right_val;
            vld_next = right_vld;
        end else if (op.pop_back) begin
            if (is_last) begin
                vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        val_reg <= val_next;
    end

endmodule

// ----- hdl/double_ended_queue_unit.sv -----
// Top level of the double-ended queue unit: cell chain, command decode and result register.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata and carry a command (push front,
//   push back, pop front, pop back, search) and a 32-bit signed value. Every accepted
//   word yields exactly one result word on m_tvalid/m_tready/m_tdata with the popped
//   value, the search flag, the front and back entries, the entry count and a status.
//   Entries live in a row of DEPTH cells, front in cell 0; push front and pop front
//   shift the whole row by one cell, push back fills the first empty cell, pop back
//   clears the back cell, and a search compares every cell at once.
// Pipeline:
//   An accepted word is held in stage 1; the cells update as status, popped value and
//   match are captured in stage 2, which then loads the result register. One item is
//   in flight at a time, so a new item is accepted only after the previous one has left
//   stage 2; it may enter while an earlier result still waits in the result register.
// Reset:
//   aresetn low for one clock empties the queue and drops any pending result.
// Stall:
//   With m_tready low the finished result holds; one further item can be taken and
//   completed to its capture stage, after which s_tready stays low until the result
//   register drains.
module double_ended_queue_unit #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata: cmd[2:0], value[34:3], zero padding above
    input  logic [deq_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata: popped_value[31:0], found[32], first_value[64:33], last_value[96:65],
    //          entry_count[103:97], status[105:104], zero padding above
    output logic [deq_pkg::M_DATA_W-1:0] m_tdata
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // stage 1: accepted command
    logic              s1_valid_reg, s1_valid_next;
    deq_cmd_t          s1_cmd_reg;
    logic [DATA_W-1:0] s1_value_reg;

    // stage 2: captured per-item results
    logic              s2_valid_reg, s2_valid_next;
    logic [DATA_W-1:0] s2_popped_reg, s2_popped_next;
    logic              s2_found_reg, s2_found_next;
    deq_status_t       s2_status_reg, s2_status_next;

    // result register
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [CNT_W-1:0] count_reg, count_next;

    logic [DATA_W-1:0] cell_val [DEPTH];
    logic [DEPTH-1:0]  cell_vld;
    logic [DEPTH-1:0]  cell_last;
    logic [DEPTH-1:0]  cell_match;
    deq_op_t           op;

    logic              q_empty, q_full;
    logic [DATA_W-1:0] last_sel;
    logic [DATA_W-1:0] first_sel;
    logic              s_accept;
    logic              m_load;

    assign s_tready = !s1_valid_reg && !s2_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_load   = s2_valid_reg && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign q_empty = !cell_vld[0];
    assign q_full  = cell_vld[DEPTH-1];

    // cell chain
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] l_val, r_val;
        logic              l_vld, r_vld;
        if (i == 0) begin : g_head
            assign l_val = s1_value_reg;
            assign l_vld = 1'b1;
        end else begin : g_body
            assign l_val = cell_val[i-1];
            assign l_vld = cell_vld[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign r_val = '0;
            assign r_vld = 1'b0;
        end else begin : g_inner
            assign r_val = cell_val[i+1];
            assign r_vld = cell_vld[i+1];
        end
        deq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (op),
            .key       (s1_value_reg),
            .left_val  (l_val),
            .left_vld  (l_vld),
            .right_val (r_val),
            .right_vld (r_vld),
            .val       (cell_val[i]),
            .vld       (cell_vld[i]),
            .is_last   (cell_last[i]),
            .match     (cell_match[i])
        );
    end

    // back entry: one-hot select over the cells, zero when empty
    always_comb begin
        last_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            last_sel = last_sel | (cell_last[i] ? cell_val[i] : '0);
        end
    end

    assign first_sel = cell_vld[0] ? cell_val[0] : '0;

    // command decode against the state before the update
    always_comb begin
        op             = '0;
        count_next     = count_reg;
        s2_popped_next = s2_popped_reg;
        s2_found_next  = s2_found_reg;
        s2_status_next = s2_status_reg;
        if (s1_valid_reg) begin
            s2_popped_next = '0;
            s2_found_next  = 1'b0;
            s2_status_next = ST_OK;
            unique case (s1_cmd_reg)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (q_full) begin
                        s2_status_next = ST_FULL;
                    end else begin
                        op.push_front = (s1_cmd_reg == CMD_PUSH_FRONT);
                        op.push_back  = (s1_cmd_reg == CMD_PUSH_BACK);
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT: begin
                    if (q_empty) begin
                        s2_status_next = ST_EMPTY;
                    end else begin
                        op.pop_front   = 1'b1;
                        s2_popped_next = cell_val[0];
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                CMD_POP_BACK: begin
                    if (q_empty) begin
                        s2_status_next = ST_EMPTY;
                    end else begin
                        op.pop_back    = 1'b1;
                        s2_popped_next = last_sel;
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                CMD_SEARCH: begin
                    s2_found_next = |cell_match;
                end
                default: begin
                end
            endcase
        end
    end

    // handshake and result assembly
    always_comb begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (m_load) begin
            m_valid_next = 1'b1;
            m_data_next  = M_DATA_W'({s2_status_reg, COUNT_W'(count_reg), last_sel,
                                      first_sel, s2_found_reg, s2_popped_reg});
            s2_valid_next = 1'b0;
        end
        if (s1_valid_reg) begin
            s1_valid_next = 1'b0;
            s2_valid_next = 1'b1;
        end
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            count_reg    <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
            count_reg    <= count_next;
        end
        if (s_accept) begin
            s1_cmd_reg   <= deq_cmd_t'(s_tdata[CMD_W-1:0]);
            s1_value_reg <= s_tdata[CMD_W +: DATA_W];
        end
        s2_popped_reg <= s2_popped_next;
        s2_found_reg  <= s2_found_next;
        s2_status_reg <= s2_status_next;
        m_data_reg    <= m_data_next;
    end

    // occupied cells form a solid run from the front
    a_vld_solid: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cell_vld >> 1) & ~cell_vld) == '0)
        else $error("gap in occupied cells");

    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CNT_W'($countones(cell_vld)))
        else $error("entry count disagrees with occupied cells");

    a_one_back: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_last))
        else $error("more than one back cell");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s1_valid_reg && s2_valid_reg))
        else $error("two items in flight");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |=> s2_valid_reg)
        else $error("captured item lost");

endmodule
